// File: rtl/core/stq_pkg.sv
// package for the sorted software timer queue
// types, codes and sizes shared by stq_list and the top level
`timescale 1ns / 1ps

package stq_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int MAX_FIRES  = 16;
	localparam int IDX_W      = $clog2(NUM_TIMERS);
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int FIRE_W     = $clog2(MAX_FIRES + 1);

	localparam logic [1:0] MODE_ONESHOT  = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_CANCEL   = 2'd2;
	localparam logic [1:0] MODE_TICK     = 2'd3;

	localparam logic [1:0] KIND_REPLY  = 2'd0;
	localparam logic [1:0] KIND_EVENTS = 2'd1;
	localparam logic [1:0] KIND_WAKE   = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_ZERO    = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic        action_kind;
		logic [31:0] delay_len;
		logic [31:0] event_mask;
		logic [31:0] owner_task;
		logic [31:0] cancel_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [31:0] timer_ident;
		logic [31:0] notify_task;
		logic [31:0] notify_events;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0] ident;
		logic [31:0] expiry;
		logic [31:0] period;
		logic        periodic;
		logic        wake;
		logic [31:0] events;
		logic [31:0] task_id;
	} entry_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [CNT_W-1:0] pos;
		entry_t           ent;
	} list_cmd_t;

endpackage

// File: rtl/core/stq_list.sv
// timer list kept in expiry order, one entry per position
// insert and remove shift the tail by one place; depends on stq_pkg
`timescale 1ns / 1ps

module stq_list (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stq_pkg::list_cmd_t       cmd,
	output logic [stq_pkg::CNT_W-1:0] count,
	output stq_pkg::entry_t          head,
	output stq_pkg::entry_t          rd
);
	import stq_pkg::*;

	entry_t           ent_q [NUM_TIMERS];
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (cmd.ins) begin
				if (CNT_W'(i) == cmd.pos)
					ent_q[i] <= cmd.ent;
				else if (i > 0 && CNT_W'(i) > cmd.pos)
					ent_q[i] <= ent_q[(i > 0) ? i - 1 : 0];
			end else if (cmd.rem) begin
				if (i < NUM_TIMERS - 1 && CNT_W'(i) >= cmd.pos)
					ent_q[i] <= ent_q[(i < NUM_TIMERS - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign count = count_q;
	assign head  = ent_q[0];
	assign rd    = ent_q[cmd.pos[IDX_W-1:0]];

endmodule

// File: rtl/core/sorted_software_timer_queue_top.sv
// top level of the sorted software timer queue: sequencer, result buffer, output register
// depends on stq_pkg and stq_list
//
//  channel | valid     | stall     | payload
//  cmd     | cmd_valid | cmd_stall | cmd (stq_pkg::cmd_t)
//  res     | res_valid | res_stall | res (stq_pkg::res_t)
//
// one list entry is compared per cycle in each scan
// create: position scan, shift insert, reply
// cancel: id scan, shift remove, reply
// tick: each fired timer is removed from the head, then scanned and reinserted if periodic
// reset clears the list count, ids restart at 1, tick count at 0
// a stalled result only holds the sequencer when a second result must leave
`timescale 1ns / 1ps

module sorted_software_timer_queue_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  stq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output stq_pkg::res_t res
);
	import stq_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCAN_INS = 3'd1;
	localparam logic [2:0] ST_INSERT   = 3'd2;
	localparam logic [2:0] ST_SCAN_CAN = 3'd3;
	localparam logic [2:0] ST_FIRE     = 3'd4;
	localparam logic [2:0] ST_FLUSH    = 3'd5;

	localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(NUM_TIMERS);
	localparam logic [FIRE_W-1:0] FIRE_LIMIT = FIRE_W'(MAX_FIRES);

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  pos_q;
	logic [FIRE_W-1:0] fires_q;
	logic              op_tick_q;
	logic [31:0]       tick_q;
	logic [31:0]       next_id_q;
	logic [31:0]       cid_q;
	entry_t            new_q;
	res_t              pend_q;
	logic              pend_v_q;
	res_t              out_q;
	logic              out_v_q;

	list_cmd_t         lcmd;
	logic [CNT_W-1:0]  count;
	entry_t            head;
	entry_t            rd;

	logic              out_free;
	logic              accept;
	logic              head_due;
	logic              fire_go;
	logic              fire_res;
	res_t              fire_r;

	stq_list u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lcmd),
		.count  (count),
		.head   (head),
		.rd     (rd)
	);

	assign out_free  = !out_v_q || !res_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign head_due  = (count != '0) && (head.expiry <= tick_q) && (fires_q != FIRE_LIMIT);
	assign fire_go   = (state_q == ST_FIRE) && head_due && (!pend_v_q || out_free);
	assign fire_res  = head.wake || (head.events != '0);

	always_comb begin
		fire_r               = '0;
		fire_r.kind          = head.wake ? KIND_WAKE : KIND_EVENTS;
		fire_r.status        = STAT_OK;
		fire_r.timer_ident   = head.ident;
		fire_r.notify_task   = head.task_id;
		fire_r.notify_events = head.wake ? 32'd0 : head.events;
	end

	always_comb begin
		lcmd     = '0;
		lcmd.pos = pos_q;
		lcmd.ent = new_q;
		case (state_q)
			ST_INSERT: lcmd.ins = 1'b1;
			ST_SCAN_CAN: begin
				if (pos_q != count && rd.ident == cid_q)
					lcmd.rem = 1'b1;
			end
			ST_FIRE: begin
				if (fire_go) begin
					lcmd.rem = 1'b1;
					lcmd.pos = '0;
				end
			end
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.expiry   <= tick_q + cmd.delay_len;
			new_q.period   <= (cmd.mode == MODE_PERIODIC) ? cmd.delay_len : 32'd0;
			new_q.periodic <= (cmd.mode == MODE_PERIODIC);
			new_q.wake     <= cmd.action_kind;
			new_q.events   <= cmd.event_mask;
			new_q.task_id  <= cmd.owner_task;
			new_q.ident    <= next_id_q;
			cid_q          <= cmd.cancel_id;
		end else if (fire_go) begin
			// periodic reload goes back through the insert path
			new_q        <= head;
			new_q.expiry <= head.expiry + head.period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			fires_q   <= '0;
			op_tick_q <= 1'b0;
			tick_q    <= '0;
			next_id_q <= 32'd1;
			pend_q    <= '0;
			pend_v_q  <= 1'b0;
			out_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_v_q && !res_stall)
				out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q     <= '0;
						fires_q   <= '0;
						op_tick_q <= (cmd.mode == MODE_TICK);
						pend_q    <= '0;
						case (cmd.mode)
							MODE_ONESHOT, MODE_PERIODIC: begin
								pend_v_q <= 1'b1;
								if (cmd.delay_len == '0) begin
									pend_q.status <= STAT_ZERO;
									state_q       <= ST_FLUSH;
								end else if (count == FULL_COUNT) begin
									pend_q.status <= STAT_FULL;
									state_q       <= ST_FLUSH;
								end else begin
									pend_q.status      <= STAT_OK;
									pend_q.timer_ident <= next_id_q;
									next_id_q <= (next_id_q == 32'hFFFF_FFFF) ? 32'd1
										: next_id_q + 32'd1;
									state_q <= ST_SCAN_INS;
								end
							end
							MODE_CANCEL: begin
								pend_v_q           <= 1'b1;
								pend_q.timer_ident <= cmd.cancel_id;
								pend_q.status      <= STAT_UNKNOWN;
								state_q <= (cmd.cancel_id == '0) ? ST_FLUSH : ST_SCAN_CAN;
							end
							default: begin
								pend_v_q <= 1'b0;
								tick_q   <= tick_q + 32'd1;
								state_q  <= ST_FIRE;
							end
						endcase
					end
				end
				ST_SCAN_INS: begin
					if (pos_q != count && rd.expiry <= new_q.expiry)
						pos_q <= pos_q + CNT_W'(1);
					else
						state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					state_q <= op_tick_q ? ST_FIRE : ST_FLUSH;
				end
				ST_SCAN_CAN: begin
					if (pos_q == count) begin
						state_q <= ST_FLUSH;
					end else if (rd.ident == cid_q) begin
						pend_q.status <= STAT_OK;
						state_q       <= ST_FLUSH;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
					end
				end
				ST_FIRE: begin
					if (!head_due) begin
						state_q <= ST_FLUSH;
					end else if (fire_go) begin
						fires_q <= fires_q + FIRE_W'(1);
						if (fire_res) begin
							// the held result is not the final one: let it go
							if (pend_v_q) begin
								out_q      <= pend_q;
								out_q.last <= 1'b0;
								out_v_q    <= 1'b1;
							end
							pend_q   <= fire_r;
							pend_v_q <= 1'b1;
						end
						if (head.periodic) begin
							pos_q   <= '0;
							state_q <= ST_SCAN_INS;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_q      <= pend_q;
						out_q.last <= 1'b1;
						out_v_q    <= 1'b1;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= FULL_COUNT)
		else $error("timer list count beyond pool size");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |-> count != FULL_COUNT)
		else $error("insert into a full list");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("result still held while idle");

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fires_q <= FIRE_LIMIT)
		else $error("too many expiries in one tick");

endmodule

// File: bench/tb_sorted_software_timer_queue_top.sv
// testbench for the sorted software timer queue top level
// depends on stq_pkg and the rtl of sorted_software_timer_queue_top
`timescale 1ns / 1ps

class timer_scoreboard;
	bit              used [16];
	logic [31:0]     ident [16];
	logic [31:0]     expiry [16];
	logic [31:0]     period [16];
	bit              periodic [16];
	bit              wake [16];
	logic [31:0]     events [16];
	logic [31:0]     task_id [16];
	int unsigned     order [16];
	int unsigned     count;
	logic [31:0]     next_id;
	logic [31:0]     ticks;
	stq_pkg::res_t   pending [$];
	int              errors;

	function new();
		count = 0;
		next_id = 1;
		ticks = 0;
		errors = 0;
		foreach (used[i]) used[i] = 1'b0;
	endfunction

	function void insert_sorted(int unsigned s);
		int unsigned pos;
		pos = 0;
		while (pos < count && expiry[order[pos]] <= expiry[s]) pos++;
		for (int unsigned j = count; j > pos; j--) order[j] = order[j - 1];
		order[pos] = s;
		count++;
	endfunction

	function void remove_at(int unsigned pos);
		for (int unsigned j = pos; j + 1 < count; j++) order[j] = order[j + 1];
		count--;
	endfunction

	function void push(logic [1:0] k, logic [1:0] st, logic [31:0] id, logic [31:0] tk,
			logic [31:0] ev, bit lst);
		stq_pkg::res_t r;
		r.kind = k;
		r.status = st;
		r.timer_ident = id;
		r.notify_task = tk;
		r.notify_events = ev;
		r.last = lst;
		pending.push_back(r);
	endfunction

	function void note_request(stq_pkg::cmd_t c);
		int unsigned s;
		int n;
		bit found;
		if (c.mode == stq_pkg::MODE_ONESHOT || c.mode == stq_pkg::MODE_PERIODIC) begin
			if (c.delay_len == 0) begin
				push(stq_pkg::KIND_REPLY, stq_pkg::STAT_ZERO, 0, 0, 0, 1'b1);
				return;
			end
			s = 0;
			while (s < 16 && used[s]) s++;
			if (s >= 16) begin
				push(stq_pkg::KIND_REPLY, stq_pkg::STAT_FULL, 0, 0, 0, 1'b1);
				return;
			end
			used[s] = 1'b1;
			ident[s] = next_id;
			next_id++;
			if (next_id == 0) next_id = 1;
			expiry[s] = ticks + c.delay_len;
			periodic[s] = (c.mode == stq_pkg::MODE_PERIODIC);
			period[s] = periodic[s] ? c.delay_len : 32'd0;
			wake[s] = c.action_kind;
			events[s] = c.event_mask;
			task_id[s] = c.owner_task;
			insert_sorted(s);
			push(stq_pkg::KIND_REPLY, stq_pkg::STAT_OK, ident[s], 0, 0, 1'b1);
			return;
		end
		if (c.mode == stq_pkg::MODE_CANCEL) begin
			found = 1'b0;
			if (c.cancel_id != 0) begin
				for (int unsigned p = 0; p < count; p++) begin
					if (ident[order[p]] == c.cancel_id) begin
						used[order[p]] = 1'b0;
						remove_at(p);
						found = 1'b1;
						break;
					end
				end
			end
			push(stq_pkg::KIND_REPLY, found ? stq_pkg::STAT_OK : stq_pkg::STAT_UNKNOWN,
				c.cancel_id, 0, 0, 1'b1);
			return;
		end
		ticks++;
		n = 0;
		for (int f = 0; f < 16; f++) begin
			if (count == 0) break;
			s = order[0];
			if (expiry[s] > ticks) break;
			remove_at(0);
			if (wake[s]) begin
				push(stq_pkg::KIND_WAKE, stq_pkg::STAT_OK, ident[s], task_id[s], 0, 1'b0);
				n++;
			end else if (events[s] != 0) begin
				push(stq_pkg::KIND_EVENTS, stq_pkg::STAT_OK, ident[s], task_id[s],
					events[s], 1'b0);
				n++;
			end
			if (periodic[s]) begin
				expiry[s] = expiry[s] + period[s];
				insert_sorted(s);
			end else begin
				used[s] = 1'b0;
			end
		end
		if (n > 0) pending[pending.size() - 1].last = 1'b1;
	endfunction

	function void check_result(stq_pkg::res_t r);
		stq_pkg::res_t e;
		if (pending.size() == 0) begin
			$error("result with none expected: kind %0d id %0d", r.kind, r.timer_ident);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (r.kind !== e.kind) begin
			$error("kind expected %0d actual %0d", e.kind, r.kind); errors++;
		end
		if (r.status !== e.status) begin
			$error("status expected %0d actual %0d", e.status, r.status); errors++;
		end
		if (r.timer_ident !== e.timer_ident) begin
			$error("timer_ident expected %0h actual %0h", e.timer_ident, r.timer_ident);
			errors++;
		end
		if (r.notify_task !== e.notify_task) begin
			$error("notify_task expected %0h actual %0h", e.notify_task, r.notify_task);
			errors++;
		end
		if (r.notify_events !== e.notify_events) begin
			$error("notify_events expected %0h actual %0h", e.notify_events,
				r.notify_events);
			errors++;
		end
		if (r.last !== e.last) begin
			$error("last expected %0d actual %0d", e.last, r.last); errors++;
		end
	endfunction
endclass

module tb_sorted_software_timer_queue_top;
	import stq_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 0;
	res_t res;

	int send_idle = 0;
	int recv_idle = 0;
	bit hold_recv = 0;
	bit hold_done = 0;
	int hold_cnt = 0;
	int idle_cycles = 0;
	logic [31:0] issued_ids [$];
	timer_scoreboard sb;

	localparam int WATCHDOG    = 20000;
	localparam int HOLD_CYCLES = 300;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	sorted_software_timer_queue_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// sample handshakes and keep the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) sb.note_request(cmd);
			if (res_valid && !res_stall) begin
				sb.check_result(res);
				if (res.kind == KIND_REPLY && res.status == STAT_OK && res.timer_ident != 0)
					issued_ids.push_back(res.timer_ident);
			end
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("sorted_software_timer_queue_top test failed");
				$finish;
			end
		end
	end

	// receiver stall, one long hold-off counted here when requested
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			res_stall <= 1;
			hold_cnt  <= hold_cnt - 1;
		end else if (hold_recv && !hold_done) begin
			res_stall <= 1;
			hold_cnt  <= HOLD_CYCLES;
			hold_done <= 1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// valid stays up after the request; the next call drops it or sends anew, the drain wait drops it
	task automatic send_request(cmd_t c);
		while ($urandom_range(99) < send_idle) begin
			cmd_valid <= 0;
			@(posedge clk);
		end
		cmd_valid <= 1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	// send without a gap so back-to-back requests keep valid high
	task automatic send_burst_item(cmd_t c);
		cmd_valid <= 1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	function automatic cmd_t random_fields();
		cmd_t c;
		c.mode = 2'($urandom);
		c.action_kind = 1'($urandom);
		c.delay_len = $urandom;
		c.event_mask = $urandom;
		c.owner_task = $urandom;
		c.cancel_id = $urandom;
		return c;
	endfunction

	function automatic cmd_t make_create(logic [1:0] m, bit w, logic [31:0] d,
			logic [31:0] ev, logic [31:0] tk);
		cmd_t c;
		c = '0;
		c.mode = m;
		c.action_kind = w;
		c.delay_len = d;
		c.event_mask = ev;
		c.owner_task = tk;
		return c;
	endfunction

	function automatic cmd_t make_cancel(logic [31:0] id);
		cmd_t c;
		c = '0;
		c.mode = MODE_CANCEL;
		c.cancel_id = id;
		return c;
	endfunction

	function automatic cmd_t make_tick();
		cmd_t c;
		c = random_fields();
		c.mode = MODE_TICK;
		return c;
	endfunction

	function automatic cmd_t random_request();
		cmd_t c;
		int r;
		r = $urandom_range(99);
		c = random_fields();
		if (r < 40) begin
			c.mode = 2'($urandom_range(1));
			case ($urandom_range(9))
				0: c.delay_len = 0;
				1: c.delay_len = $urandom;
				2: c.delay_len = 32'hffff_ffff;
				default: c.delay_len = $urandom_range(12, 1);
			endcase
			if ($urandom_range(5) == 0) c.event_mask = 0;
		end else if (r < 55) begin
			c.mode = MODE_CANCEL;
			if (issued_ids.size() > 0 && $urandom_range(3) != 0)
				c.cancel_id = issued_ids[$urandom_range(issued_ids.size() - 1)];
			else if ($urandom_range(1))
				c.cancel_id = 0;
		end else begin
			c.mode = MODE_TICK;
		end
		return c;
	endfunction

	task automatic wait_drained();
		cmd_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) send_request(random_request());
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: rejects, extremes, empty mask, wake, cancel cases, burst
		send_idle = 9; recv_idle = 73;
		send_request(make_create(MODE_ONESHOT, 1'b0, 0, 32'h1, 32'h2));
		send_request(make_create(MODE_PERIODIC, 1'b1, 0, 32'h1, 32'h2));
		send_request(make_create(MODE_ONESHOT, 1'b0, 1, 32'hffff_ffff, 32'hffff_ffff));
		send_request(make_create(MODE_ONESHOT, 1'b0, 1, 32'h0, 32'h5));
		send_request(make_create(MODE_PERIODIC, 1'b1, 2, 32'h0, 32'h7));
		send_request(make_create(MODE_ONESHOT, 1'b0, 32'hffff_ffff, 32'h8, 32'h9));
		send_request(make_tick());
		send_request(make_cancel(0));
		send_request(make_cancel(32'hdead_beef));
		send_request(make_cancel(5));
		send_request(make_cancel(5));
		for (int i = 0; i < 14; i++)
			send_request(make_create(MODE_PERIODIC, i[0], 1, $urandom | 1, $urandom));
		send_request(make_create(MODE_ONESHOT, 1'b0, 3, 1, 1));
		send_request(make_create(MODE_ONESHOT, 1'b1, 0, 1, 1));
		send_request(make_tick());
		send_request(make_tick());
		wait_drained();

		// long receiver hold-off while requests keep coming
		hold_recv = 1;
		for (int i = 0; i < 12; i++) send_burst_item(make_tick());
		cmd_valid <= 0;
		hold_recv = 0;
		wait_drained();
		for (int i = 0; i < 16; i++) send_request(make_cancel(issued_ids[i]));
		wait_drained();

		run_random(33);
		wait_drained();
		send_idle = 73; recv_idle = 9;
		run_random(33);
		wait_drained();
		send_idle = 0; recv_idle = 0;
		run_random(33);
		wait_drained();
		repeat (100) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("sorted_software_timer_queue_top test passed");
		else
			$display("sorted_software_timer_queue_top test failed");
		$finish;
	end
endmodule
